/* rtl/core/bfa_pkg.sv */
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared widths, codes and types of the first-fit bitmap block allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  // Field widths of the transfer payloads
  localparam int FUNC_W = 2;
  localparam int IDX_W  = 13;
  localparam int STAT_W = 2;
  localparam int LIM_W  = 14;
  localparam int CNT_W  = 14;

  // Defaults for the top-level parameters
  localparam int NUM_BLOCKS_DEF = 8192;
  localparam int WORD_BITS_DEF  = 64;

  // Block limit after reset
  localparam logic [LIM_W-1:0] LIMIT_RESET = 14'd8000;

  // Request codes (code 3 behaves as a test)
  localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FN_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_TEST  = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_FREE  = 2'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_FIX,
    S_RD,
    S_MOD,
    S_DONE
  } state_t;

endpackage

/* rtl/core/bfa_ram.sv */
// ----------------------------------------------------------------------------
// bfa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/bfa_find.sv */
// ----------------------------------------------------------------------------
// bfa_find
// Lowest free bit of one bitmap word, restricted to blocks below the limit.
// ----------------------------------------------------------------------------
module bfa_find #(
  parameter int WORD_BITS = 64,
  parameter int BASE_W    = 14,
  parameter int BIT_W     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1
) (
  input  logic [WORD_BITS-1:0] word,   // used bits of this word
  input  logic [BASE_W-1:0]    rem,    // blocks left below the limit
  output logic                 found,
  output logic [BIT_W-1:0]     pos
);

  logic [WORD_BITS-1:0] in_range;
  logic [WORD_BITS-1:0] cand;

  // bits of this word that still lie below the limit
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      in_range[j] = (BASE_W'(j) < rem);
    end
  end

  assign cand  = ~word & in_range;
  assign found = |cand;

  // priority encode, lowest index wins
  always_comb begin
    pos = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (cand[j]) begin
        pos = BIT_W'(j);
      end
    end
  end

endmodule

/* rtl/core/bitmap_first_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_first_fit_block_allocator
// Used-block bitmap in one word-wide RAM with first-fit allocate, free and
// test requests, a used-block count and a programmable block limit.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  in_func, in_block_index
//   out      output     out_valid/out_stall out_granted_index, out_status,
//                                          out_was_used, out_used_total
//   cfg      input      cfg_we             cfg_wdata (block limit)
//
// One request at a time. Allocate reads one bitmap word per cycle, scanning from
// word 0 until a free block below the limit is found or the limit is reached.
// Free and test go through index split, read, modify/write and result.
// Out-of-range free or test goes straight to the result.
// Reset clears the per-word valid bits, so the bitmap reads all free at once.
// A stalled result holds the output register; the next request runs and waits at DONE.
// ----------------------------------------------------------------------------
module bitmap_first_fit_block_allocator #(
  parameter int NUM_BLOCKS = bfa_pkg::NUM_BLOCKS_DEF,
  parameter int WORD_BITS  = bfa_pkg::WORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [bfa_pkg::FUNC_W-1:0] in_func,
  input  logic [bfa_pkg::IDX_W-1:0]  in_block_index,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bfa_pkg::IDX_W-1:0]  out_granted_index,
  output logic [bfa_pkg::STAT_W-1:0] out_status,
  output logic                       out_was_used,
  output logic [bfa_pkg::CNT_W-1:0]  out_used_total,
  // configuration
  input  logic                       cfg_we,
  input  logic [bfa_pkg::LIM_W-1:0]  cfg_wdata
);

  localparam int IDX_W     = bfa_pkg::IDX_W;
  localparam int LIM_W     = bfa_pkg::LIM_W;
  localparam int CNT_W     = bfa_pkg::CNT_W;
  localparam int STAT_W    = bfa_pkg::STAT_W;
  localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CW        = $clog2(MAP_WORDS + 1);
  localparam int BASE_W    = $clog2(MAP_WORDS * WORD_BITS + 1);
  localparam int BIT_W     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  // reciprocal for the index split into word and bit
  localparam int SH        = IDX_W + BIT_W + 1;
  localparam int RECIP     = (2 ** SH) / WORD_BITS;
  localparam int PROD_W    = IDX_W + SH + 1;
  localparam int QM_W      = IDX_W + BIT_W + 1;
  // highest limit that still matters
  localparam int LIM_MAX   = (1 << LIM_W) - 1;
  localparam int LIM_CAP   = (NUM_BLOCKS > LIM_MAX) ? LIM_MAX : NUM_BLOCKS;

  // state
  bfa_pkg::state_t      state_r, state_nxt;
  logic [LIM_W-1:0]     lim_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [MAP_WORDS-1:0] row_vld_r;
  logic                 vld_q_r;
  logic                 out_valid_r, out_valid_nxt;

  // request context
  logic [bfa_pkg::FUNC_W-1:0] func_r;
  logic [IDX_W-1:0]     idx_r;
  logic [CW-1:0]        chk_w_r;
  logic [BASE_W-1:0]    chk_base_r;
  logic [IDX_W-1:0]     qest_r;
  logic [AW-1:0]        word_r;
  logic [BIT_W-1:0]     bit_r;

  // pending result
  logic [IDX_W-1:0]     res_granted_r, res_granted_nxt;
  logic [STAT_W-1:0]    res_status_r, res_status_nxt;
  logic                 res_was_r, res_was_nxt;
  logic                 res_load;

  // output register payload
  logic [IDX_W-1:0]     out_granted_r;
  logic [STAT_W-1:0]    out_status_r;
  logic                 out_was_r;
  logic [CNT_W-1:0]     out_total_r;

  // RAM port
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // datapath
  logic [LIM_W-1:0]     eff_lim;
  logic [BASE_W-1:0]    lim_ext;
  logic [BASE_W-1:0]    scan_rem;
  logic                 scan_end;
  logic                 find_ok;
  logic [BIT_W-1:0]     find_pos;
  logic [WORD_BITS-1:0] word_cur;
  logic                 bit_cur;
  logic [CW-1:0]        scan_next_w;
  logic                 in_xfer;
  logic                 in_oor;
  logic                 slot_free;
  logic [PROD_W-1:0]    div_prod;
  logic [QM_W-1:0]      fix_mul;
  logic [QM_W-1:0]      fix_rem;
  logic                 fix_over;

  // effective limit, saturated at the block count
  assign eff_lim = (lim_r > LIM_W'(LIM_CAP)) ? LIM_W'(LIM_CAP) : lim_r;
  assign lim_ext = BASE_W'(eff_lim);

  assign in_stall  = (state_r != bfa_pkg::S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign in_oor    = ({1'b0, in_block_index} >= eff_lim);
  assign slot_free = !out_valid_r || !out_stall;

  // current word: rows never written read as all free
  assign word_cur = vld_q_r ? ram_rdata : '0;
  assign bit_cur  = word_cur[bit_r];

  // scan bookkeeping
  assign scan_end    = (chk_base_r >= lim_ext);
  assign scan_rem    = lim_ext - chk_base_r;
  assign scan_next_w = chk_w_r + CW'(1);

  bfa_find #(
    .WORD_BITS (WORD_BITS),
    .BASE_W    (BASE_W),
    .BIT_W     (BIT_W)
  ) u_find (
    .word  (word_cur),
    .rem   (scan_rem),
    .found (find_ok),
    .pos   (find_pos)
  );

  // index split: estimate, then one correction step
  assign div_prod = PROD_W'(idx_r) * PROD_W'(RECIP);
  assign fix_mul  = QM_W'(qest_r) * QM_W'(WORD_BITS);
  assign fix_rem  = QM_W'(idx_r) - fix_mul;
  assign fix_over = (fix_rem >= QM_W'(WORD_BITS));

  bfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bfa_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (in_func == bfa_pkg::FN_ALLOC) begin
            state_nxt = bfa_pkg::S_SCAN;
          end else if (in_oor) begin
            state_nxt = bfa_pkg::S_DONE;
          end else begin
            state_nxt = bfa_pkg::S_DIV;
          end
        end
      end
      bfa_pkg::S_SCAN: begin
        if (scan_end || find_ok) begin
          state_nxt = bfa_pkg::S_DONE;
        end
      end
      bfa_pkg::S_DIV:  state_nxt = bfa_pkg::S_FIX;
      bfa_pkg::S_FIX:  state_nxt = bfa_pkg::S_RD;
      bfa_pkg::S_RD:   state_nxt = bfa_pkg::S_MOD;
      bfa_pkg::S_MOD:  state_nxt = bfa_pkg::S_DONE;
      bfa_pkg::S_DONE: begin
        if (slot_free) begin
          state_nxt = bfa_pkg::S_IDLE;
        end
      end
      default: state_nxt = bfa_pkg::S_IDLE;
    endcase
  end

  // state outputs: RAM access, count update, result capture
  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = word_r;
    ram_wdata       = word_cur;
    ram_raddr       = '0;
    cnt_nxt         = cnt_r;
    res_load        = 1'b0;
    res_granted_nxt = idx_r;
    res_status_nxt  = bfa_pkg::ST_OK;
    res_was_nxt     = 1'b0;
    case (state_r)
      bfa_pkg::S_IDLE: begin
        // word 0 is fetched as an allocate is taken
        res_load        = in_xfer;
        res_granted_nxt = in_block_index;
        res_status_nxt  = bfa_pkg::ST_RANGE;
      end
      bfa_pkg::S_SCAN: begin
        ram_raddr = scan_next_w[AW-1:0];
        if (scan_end) begin
          res_load        = 1'b1;
          res_granted_nxt = '0;
          res_status_nxt  = bfa_pkg::ST_FULL;
        end else if (find_ok) begin
          ram_we          = 1'b1;
          ram_waddr       = chk_w_r[AW-1:0];
          ram_wdata       = word_cur | (WORD_BITS'(1) << find_pos);
          cnt_nxt         = cnt_r + CNT_W'(1);
          res_load        = 1'b1;
          res_granted_nxt = IDX_W'(chk_base_r + BASE_W'(find_pos));
          res_status_nxt  = bfa_pkg::ST_OK;
        end
      end
      bfa_pkg::S_RD: begin
        ram_raddr = word_r;
      end
      bfa_pkg::S_MOD: begin
        res_load = 1'b1;
        if (func_r == bfa_pkg::FN_FREE) begin
          if (bit_cur) begin
            ram_we      = 1'b1;
            ram_wdata   = word_cur & ~(WORD_BITS'(1) << bit_r);
            res_was_nxt = 1'b1;
            if (cnt_r != '0) begin
              cnt_nxt = cnt_r - CNT_W'(1);
            end
          end else begin
            res_status_nxt = bfa_pkg::ST_FREE;
          end
        end else begin
          res_was_nxt = bit_cur;
        end
      end
      default: begin
      end
    endcase
  end

  // output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == bfa_pkg::S_DONE && slot_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfa_pkg::S_IDLE;
      lim_r       <= bfa_pkg::LIMIT_RESET;
      cnt_r       <= '0;
      row_vld_r   <= '0;
      vld_q_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        lim_r <= cfg_wdata;
      end
      if (ram_we) begin
        row_vld_r[ram_waddr] <= 1'b1;
      end
      // valid bit is registered alongside the RAM read data
      if (32'(ram_raddr) < MAP_WORDS) begin
        vld_q_r <= row_vld_r[ram_raddr];
      end else begin
        vld_q_r <= 1'b0;
      end
    end
  end

  // request context and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_r     <= in_func;
      idx_r      <= in_block_index;
      chk_w_r    <= '0;
      chk_base_r <= '0;
    end
    if (state_r == bfa_pkg::S_SCAN) begin
      chk_w_r    <= scan_next_w;
      chk_base_r <= chk_base_r + BASE_W'(WORD_BITS);
    end
    if (state_r == bfa_pkg::S_DIV) begin
      qest_r <= IDX_W'(div_prod >> SH);
    end
    if (state_r == bfa_pkg::S_FIX) begin
      if (fix_over) begin
        word_r <= AW'(qest_r + IDX_W'(1));
        bit_r  <= BIT_W'(fix_rem - QM_W'(WORD_BITS));
      end else begin
        word_r <= AW'(qest_r);
        bit_r  <= BIT_W'(fix_rem);
      end
    end
    if (res_load) begin
      res_granted_r <= res_granted_nxt;
      res_status_r  <= res_status_nxt;
      res_was_r     <= res_was_nxt;
    end
    if (state_r == bfa_pkg::S_DONE && slot_free) begin
      out_granted_r <= res_granted_r;
      out_status_r  <= res_status_r;
      out_was_r     <= res_was_r;
      out_total_r   <= cnt_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_granted_index = out_granted_r;
  assign out_status        = out_status_r;
  assign out_was_used      = out_was_r;
  assign out_used_total    = out_total_r;

endmodule

/* test/tb_bitmap_first_fit_block_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_first_fit_block_allocator
// Self-checking bench for the first-fit bitmap block allocator. A queue-fed
// driver sends allocate, free and test requests in bursts. A predictor with
// its own bitmap, used count and limit computes each result at acceptance.
// A monitor checks every result transfer field by field while the result
// side stalls on a rolling pattern. The block limit is rewritten between
// phases, from zero through saturation.
// ----------------------------------------------------------------------------
module tb_bitmap_first_fit_block_allocator;
  import bfa_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int NUM_BLK      = NUM_BLOCKS_DEF;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 200;
  // spare request code, handled as a test
  localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] fn;
    logic [IDX_W-1:0]  idx;
  } bitmap_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]  granted;
    logic [STAT_W-1:0] status;
    logic              was_used;
    logic [CNT_W-1:0]  total;
  } bitmap_rsp_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic [FUNC_W-1:0] in_func = FN_ALLOC;
  logic [IDX_W-1:0]  in_block_index = '0;
  logic              out_stall = 1'b0;
  logic              cfg_we = 1'b0;
  logic [LIM_W-1:0]  cfg_wdata = LIMIT_RESET;

  logic              in_stall;
  logic              out_valid;
  logic [IDX_W-1:0]  out_granted_index;
  logic [STAT_W-1:0] out_status;
  logic              out_was_used;
  logic [CNT_W-1:0]  out_used_total;

  // predictor state: used bits, used count, programmed limit
  bit               used_bits [NUM_BLK];
  int unsigned      used_cnt = 0;
  logic [LIM_W-1:0] block_limit = LIMIT_RESET;

  bitmap_req_t queued_reqs[$];
  bitmap_rsp_t predicted_results[$];

  int          errors = 0;
  int unsigned cycles = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  logic [15:0] stall_pat = '0;
  int          stall_age = 0;

  bitmap_first_fit_block_allocator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_block_index    (in_block_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_granted_index (out_granted_index),
    .out_status        (out_status),
    .out_was_used      (out_was_used),
    .out_used_total    (out_used_total),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  // Effective limit: the programmed value saturates at the block count
  function automatic int eff_limit();
    return (block_limit > NUM_BLK) ? NUM_BLK : int'(block_limit);
  endfunction

  // Apply one request to the shadow bitmap and return the result it gives
  function automatic bitmap_rsp_t predict_bitmap_op(input logic [FUNC_W-1:0] fn,
                                                    input logic [IDX_W-1:0] idx);
    bitmap_rsp_t r;
    int          lim;
    bit          hit;
    lim        = eff_limit();
    r.granted  = idx;
    r.status   = ST_OK;
    r.was_used = 1'b0;
    if (fn == FN_ALLOC) begin
      // first fit from block 0 up to the limit
      r.granted = '0;
      r.status  = ST_FULL;
      hit       = 1'b0;
      for (int i = 0; i < lim && !hit; i++) begin
        if (!used_bits[i]) begin
          used_bits[i] = 1'b1;
          used_cnt++;
          r.granted = IDX_W'(i);
          r.status  = ST_OK;
          hit       = 1'b1;
        end
      end
    end else if (int'(idx) >= lim) begin
      r.status = ST_RANGE;
    end else if (fn == FN_FREE) begin
      if (used_bits[idx]) begin
        r.was_used     = 1'b1;
        used_bits[idx] = 1'b0;
        if (used_cnt > 0) used_cnt--;
      end else begin
        // double free is flagged, state untouched
        r.status = ST_FREE;
      end
    end else begin
      r.was_used = used_bits[idx];
    end
    r.total = CNT_W'(used_cnt);
    return r;
  endfunction

  // Random request; most indices land in the low window where first fit
  // packs the used blocks, the rest hit the limit edge, the full range, zero or all ones
  function automatic bitmap_req_t gen_req(input int alloc_pct);
    bitmap_req_t q;
    int          eff;
    int          r;
    int          win;
    eff = eff_limit();
    r   = $urandom_range(99);
    if (r < alloc_pct) q.fn = FN_ALLOC;
    else if (r < alloc_pct + (100 - alloc_pct) / 2) q.fn = FN_FREE;
    else if (r < 95) q.fn = FN_TEST;
    else q.fn = FN_SPARE;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        win   = (eff < 96) ? eff : 96;
        q.idx = (win > 0) ? IDX_W'($urandom_range(win - 1)) : '0;
      end
      6, 7: q.idx = IDX_W'($urandom);
      8: q.idx = IDX_W'(eff - int'($urandom_range(1)));
      default: q.idx = ($urandom_range(1) != 0) ? '1 : '0;
    endcase
    return q;
  endfunction

  task automatic push_req(input logic [FUNC_W-1:0] fn, input int idx);
    bitmap_req_t q;
    q.fn  = fn;
    q.idx = IDX_W'(idx);
    queued_reqs.push_back(q);
  endtask

  // Block is idle once nothing is queued, driven or outstanding
  task automatic wait_idle();
    while (queued_reqs.size() != 0 || in_valid || predicted_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_limit(input int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= LIM_W'(value);
    @(posedge clk);
    cfg_we      <= 1'b0;
    block_limit = LIM_W'(value);
    @(negedge clk);
  endtask

  task automatic random_phase(input int n, input int alloc_pct);
    for (int k = 0; k < n; k++) queued_reqs.push_back(gen_req(alloc_pct));
    wait_idle();
  endtask

  // Stimulus sequence
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty map, double free, first fit refill, range edges
    push_req(FN_TEST, 0);
    push_req(FN_FREE, 0);
    push_req(FN_ALLOC, 8191);
    push_req(FN_ALLOC, 0);
    push_req(FN_ALLOC, 'h1555);
    push_req(FN_TEST, 1);
    push_req(FN_FREE, 1);
    push_req(FN_TEST, 1);
    push_req(FN_ALLOC, 'h0AAA);
    push_req(FN_SPARE, 2);
    push_req(FN_SPARE, 8191);
    push_req(FN_FREE, 7999);
    push_req(FN_TEST, 7999);
    push_req(FN_TEST, 8000);
    push_req(FN_FREE, 8191);
    push_req(FN_ALLOC, 0);
    push_req(FN_FREE, 0);
    push_req(FN_FREE, 0);
    push_req(FN_TEST, 'h1555);
    push_req(FN_FREE, 'h0AAA);
    push_req(FN_ALLOC, 0);
    push_req(FN_TEST, 0);
    wait_idle();
    random_phase(150, 55);

    // saturating limit, then the tiny and empty ranges
    write_limit(16383);
    random_phase(150, 50);
    write_limit(1);
    random_phase(80, 50);
    write_limit(0);
    random_phase(60, 40);
    write_limit(64);
    random_phase(200, 60);
    write_limit(65);
    random_phase(100, 50);
    write_limit(8192);
    random_phase(200, 85);
    write_limit(3);
    random_phase(100, 45);
    write_limit(8191);
    random_phase(100, 40);
    write_limit(100);
    random_phase(150, 70);
    write_limit(8000);
    random_phase(130, 30);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predicted_results.size() != 0) begin
      $error("%0d results never arrived", predicted_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb_bitmap_first_fit_block_allocator: PASS");
    end else begin
      $display("tb_bitmap_first_fit_block_allocator: FAIL");
    end
    $finish;
  end

  // Request driver: bursts of random length with random gaps
  always @(posedge clk) begin : drive_proc
    bitmap_req_t nxt;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid && !in_stall)
        predicted_results.push_back(predict_bitmap_op(in_func, in_block_index));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (queued_reqs.size() != 0) begin
          nxt = queued_reqs.pop_front();
          in_valid       <= 1'b1;
          in_func        <= nxt.fn;
          in_block_index <= nxt.idx;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(24);
            gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and stall pattern
  always @(posedge clk) begin : watch_proc
    bitmap_rsp_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          $error("result with nothing outstanding: granted_index %0d, status %0d",
                 out_granted_index, out_status);
          errors++;
        end else begin
          want = predicted_results.pop_front();
          if (out_granted_index !== want.granted) begin
            $error("granted_index: expected %0d, got %0d", want.granted, out_granted_index);
            errors++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            errors++;
          end
          if (out_was_used !== want.was_used) begin
            $error("was_used: expected %0d, got %0d", want.was_used, out_was_used);
            errors++;
          end
          if (out_used_total !== want.total) begin
            $error("used_total: expected %0d, got %0d", want.total, out_used_total);
            errors++;
          end
        end
      end
      // rotate a 16-bit stall pattern, reshuffled when the age counter wraps
      if (stall_age == 63) begin
        stall_age = 0;
        case ($urandom_range(3))
          0: stall_pat = '0;
          1: stall_pat = 16'($urandom & $urandom);
          2: stall_pat = 16'($urandom);
          default: stall_pat = 16'($urandom | $urandom);
        endcase
      end else begin
        stall_age++;
        stall_pat = {stall_pat[0], stall_pat[15:1]};
      end
      out_stall <= stall_pat[0];
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_bitmap_first_fit_block_allocator: FAIL");
      $finish;
    end
  end

endmodule
